FILE: hdl/pie_pkg.sv
// shared types and constants for the prefix instruction encoder
// no dependencies

package pie_pkg;

  localparam int NIB_BITS = 4;
  localparam int OPERAND_BITS = 32;
  localparam int NIBBLES = OPERAND_BITS / NIB_BITS;
  localparam int IDX_BITS = $clog2(NIBBLES);

  localparam logic [7:0] PFIX_CODE = 8'h20;
  localparam logic [7:0] NFIX_CODE = 8'h60;

  typedef logic [IDX_BITS-1:0] nib_idx_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } pie_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } pie_status_t;

endpackage

FILE: hdl/pie_ctrl.sv
// controller for the prefix instruction encoder: idle / emit sequencing
// depends on pie_pkg

module pie_ctrl import pie_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  pie_status_t status,
  output pie_cmd_t    cmd,
  output logic        busy,
  output logic        strobe
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;
  logic emitting;
  logic accept;

  assign emitting = (state == ST_EMIT);
  // a new transaction may be taken on the cycle the final byte goes out
  assign busy     = emitting && !status.last;
  assign accept   = start && !busy;
  assign strobe   = emitting;
  assign cmd.load = accept;
  assign cmd.step = emitting && !status.last;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.last && !accept) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_busy_only_emit: assert property (@(posedge clk) disable iff (rst)
    busy |-> emitting)
    else $error("busy outside emit state");

  a_accept_emits: assert property (@(posedge clk) disable iff (rst)
    accept |=> emitting)
    else $error("accepted transaction did not start emitting");

  a_seq_continues: assert property (@(posedge clk) disable iff (rst)
    (emitting && !status.last) |=> emitting)
    else $error("byte sequence cut short");

endmodule

FILE: hdl/pie_datapath.sv
// datapath for the prefix instruction encoder: operand hold, nibble counter,
// byte formation and size rule; depends on pie_pkg

module pie_datapath import pie_pkg::*; #(
  parameter int WORD_BYTES = 4
) (
  input  logic              clk,
  input  pie_cmd_t          cmd,
  input  logic [7:0]        opcode,
  input  logic signed [31:0] operand,
  output pie_status_t       status,
  output logic [7:0]        code_byte,
  output logic [3:0]        byte_count
);

  localparam logic [4:0] SIZE_CAP = 5'(2 * WORD_BYTES + 1);

  logic [7:0]  op;
  logic [31:0] val;
  logic        neg;
  nib_idx_t    top_idx;
  nib_idx_t    idx;
  logic [3:0]  size;

  logic        in_neg;
  logic [31:0] mag;
  nib_idx_t    hi;
  nib_idx_t    k_in;
  logic [3:0]  n_in;
  logic [3:0]  size_in;
  logic [3:0]  nib;

  assign in_neg = operand[31];
  // complement for negatives so the leading nibble search is shared
  assign mag    = in_neg ? ~operand : operand;

  always_comb begin
    hi = '0;
    for (int j = 1; j < NIBBLES; j++) begin
      if (mag[j*NIB_BITS +: NIB_BITS] != '0) hi = nib_idx_t'(j);
    end
  end

  // negatives always carry the nfix byte
  assign k_in    = (in_neg && hi == '0) ? nib_idx_t'(1) : hi;
  assign n_in    = 4'(k_in) + 4'd1;
  assign size_in = (5'(n_in) > SIZE_CAP) ? SIZE_CAP[3:0] : n_in;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= opcode;
      val     <= operand;
      neg     <= in_neg;
      top_idx <= k_in;
      idx     <= k_in;
      size    <= size_in;
    end else if (cmd.step) begin
      idx <= idx - nib_idx_t'(1);
    end
  end

  assign nib = val[{idx, 2'b00} +: NIB_BITS];

  always_comb begin
    if (idx == '0) begin
      code_byte = op | {4'b0000, val[3:0]};
    end else if (neg && idx == top_idx) begin
      code_byte = NFIX_CODE | {4'b0000, ~nib};
    end else begin
      code_byte = PFIX_CODE | {4'b0000, nib};
    end
  end

  assign status.last = (idx == '0);
  assign byte_count  = size;

endmodule

FILE: hdl/prefix_instruction_encoder.sv
// channel   signals                                   transaction
// command   start, busy, opcode, operand               start && !busy
// result    strobe, code_byte, last_byte, byte_count   strobe (one cycle, no stall)
//
// an operand taking n bytes (1 to 8) is emitted one byte per cycle once
// accepted; busy drops on the cycle of the final byte, so a new command is
// taken then and transactions can run back to back with no gap between them
// synchronous active-high reset returns the controller to idle
// the receiver cannot stall; results are never held
// depends on pie_pkg, pie_ctrl, pie_datapath

module prefix_instruction_encoder import pie_pkg::*; #(
  parameter int WORD_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         opcode,
  input  logic signed [31:0] operand,
  output logic               strobe,
  output logic [7:0]         code_byte,
  output logic               last_byte,
  output logic [3:0]         byte_count
);

  pie_cmd_t    cmd;
  pie_status_t status;

  pie_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  pie_datapath #(
    .WORD_BYTES (WORD_BYTES)
  ) u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .opcode     (opcode),
    .operand    (operand),
    .status     (status),
    .code_byte  (code_byte),
    .byte_count (byte_count)
  );

  assign last_byte = status.last;

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    strobe |-> byte_count != 4'd0)
    else $error("byte count of zero on a result");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_byte) |=> $stable(byte_count))
    else $error("byte count changed within a transaction");

  a_opcode_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_byte) |=> strobe)
    else $error("result stream ended without the opcode byte");

endmodule
